@@ src/pid_step_with_antiwindup_core_defines.svh @@
// Assertion macros for the PID step core.
`ifndef PID_STEP_WITH_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_STEP_WITH_ANTIWINDUP_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PIDAW_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PIDAW_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pidaw_pkg.sv @@
package pidaw_pkg;

  // Field and register widths.
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned TERM_W     = 62;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd5;

  // Timing constants in microseconds.
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD_US = 20'd1000;
  localparam logic [PERIOD_W-1:0] US_PER_S          = 20'd1000000;

  // Each term magnitude saturates at 2^61.
  localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, 61'd0};

  // Input item: setpoint and measurement, signed Q16.16.
  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
  } pidaw_in_t;

  // Result item: controller drive and clamp flag.
  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
  } pidaw_out_t;

endpackage

@@ src/pid_step_with_antiwindup_core.sv @@
// PID controller step with anti-windup clamp, all values signed Q16.16. Each input item
// (setpoint, measured) yields exactly one result item (drive, limited). The error is added
// to a saturating 48-bit integral; the drive is gain_p*err + gain_i*sum*T + gain_d*der/T
// with T = period_us/1e6 (period_us = 0 selects 1000 us), saturated to 32 bits and, when
// drive_max > drive_min, clamped to the limits with the step's error backed out of the
// integral if it pushed toward the violated limit. All multiplies and divides run through one
// shared 100-bit shift-add/subtract unit that handles one multiplier bit or one quotient bit per
// cycle. in_stall is high from acceptance until the result is registered; the next item is
// accepted the cycle after the result is registered, even if the result is still waiting to
// be taken. Configuration must be written only while the block is idle; the block itself does
// not enforce this. Writes to indexes 6 and 7 are ignored.
`include "pid_step_with_antiwindup_core_defines.svh"

module pid_step_with_antiwindup_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  pidaw_pkg::pidaw_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output pidaw_pkg::pidaw_out_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // Term being computed.
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // Saturate a 49-bit sum to the signed 48-bit integral range.
  function automatic logic [47:0] sat48(input logic [48:0] v);
    logic [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  // Configuration registers.
  logic signed [31:0] gain_p_r, gain_p_nxt;
  logic signed [31:0] gain_i_r, gain_i_nxt;
  logic signed [31:0] gain_d_r, gain_d_nxt;
  logic [19:0]        period_r, period_nxt;
  logic signed [31:0] drive_max_r, drive_max_nxt;
  logic signed [31:0] drive_min_r, drive_min_nxt;

  // Controller state.
  logic signed [47:0] error_sum_r, error_sum_nxt;
  logic signed [31:0] prev_error_r, prev_error_nxt;

  // Sequencer and datapath registers.
  logic [2:0]         state_r, state_nxt;
  logic [1:0]         tsel_r, tsel_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic [99:0]        prod_r, prod_nxt;
  logic [79:0]        mcand_r, mcand_nxt;
  logic [31:0]        mplier_r, mplier_nxt;
  logic [19:0]        rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [32:0] der_r, der_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic               limited_r, limited_nxt;

  // Shared unit and helpers.
  logic [99:0]        alu_a, alu_b, alu_sum;
  logic               alu_cin;
  logic               alu_ge;
  logic               in_acc;
  logic [19:0]        per_eff;
  logic [19:0]        div_d;
  logic [19:0]        mul2_op;
  logic [32:0]        diff_in;
  logic signed [31:0] err_in;
  logic signed [32:0] der_in;
  logic [48:0]        sum_add;
  logic [48:0]        sum_sub;
  logic [61:0]        term_mag;
  logic [63:0]        term_u;
  logic signed [63:0] term_s;
  logic signed [31:0] drive_sat;
  logic               acc_ovf;
  logic               slot_free;

  // Conditions watched by the assertions.
  logic               start_set;
  logic               sum_quiet;
  logic               out_quiet;
  logic               div_add;
  logic               term_cap_ok;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_data.drive   = drive_r;
  assign out_data.limited = limited_r;

  // Effective period, divisor and second multiplier for the current term.
  assign per_eff = (period_r == 20'd0) ? pidaw_pkg::DEFAULT_PERIOD_US : period_r;
  assign div_d   = (tsel_r == TERM_I) ? pidaw_pkg::US_PER_S : per_eff;
  assign mul2_op = (tsel_r == TERM_I) ? per_eff : pidaw_pkg::US_PER_S;

  // Error, integral update and derivative for a new item.
  assign diff_in = {in_data.setpoint[31], in_data.setpoint}
                 - {in_data.measured[31], in_data.measured};
  always_comb begin
    if (diff_in[32] != diff_in[31]) begin
      err_in = diff_in[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_in = $signed(diff_in[31:0]);
    end
  end
  assign sum_add = {error_sum_r[47], error_sum_r} + {{17{err_in[31]}}, err_in};
  assign der_in  = (prev_error_r == 32'sd0) ? 33'sd0
                 : ($signed({err_in[31], err_in}) - $signed({prev_error_r[31], prev_error_r}));

  // Back-out of the current error from the integral.
  assign sum_sub = {error_sum_r[47], error_sum_r} - {{17{err_r[31]}}, err_r};

  // Shared add/subtract unit: shift-add for multiply, trial subtract for divide.
  always_comb begin
    alu_a   = 100'd0;
    alu_b   = 100'd0;
    alu_cin = 1'b0;
    case (state_r)
      S_MUL1, S_MUL2: begin
        alu_a = {prod_r[98:0], 1'b0};
        alu_b = mplier_r[31] ? {20'd0, mcand_r} : 100'd0;
      end
      S_CHK: begin
        alu_a   = {77'd0, prod_r[99:77]};
        alu_b   = ~{80'd0, div_d};
        alu_cin = 1'b1;
      end
      S_DIV: begin
        alu_a   = {79'd0, rem_r, prod_r[60]};
        alu_b   = ~{80'd0, div_d};
        alu_cin = 1'b1;
      end
      default: begin
        alu_cin = 1'b0;
      end
    endcase
  end
  assign alu_sum = alu_a + alu_b + {99'd0, alu_cin};
  assign alu_ge  = ~alu_sum[99];

  // Signed term value to accumulate.
  assign term_mag = (tsel_r == TERM_P) ? prod_r[77:16] : prod_r[61:0];
  assign term_u   = {2'b00, term_mag};
  assign term_s   = neg_r ? -$signed(term_u) : $signed(term_u);

  // Saturate the accumulated drive to 32 bits.
  assign acc_ovf = (acc_r[63:31] != {33{acc_r[63]}});
  assign drive_sat = acc_ovf ? (acc_r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                             : $signed(acc_r[31:0]);

  // Configuration writes.
  always_comb begin
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    period_nxt    = period_r;
    drive_max_nxt = drive_max_r;
    drive_min_nxt = drive_min_r;
    if (cfg_we) begin
      case (cfg_index)
        pidaw_pkg::CFG_GAIN_P:    gain_p_nxt    = $signed(cfg_data);
        pidaw_pkg::CFG_GAIN_I:    gain_i_nxt    = $signed(cfg_data);
        pidaw_pkg::CFG_GAIN_D:    gain_d_nxt    = $signed(cfg_data);
        pidaw_pkg::CFG_PERIOD:    period_nxt    = cfg_data[19:0];
        pidaw_pkg::CFG_DRIVE_MAX: drive_max_nxt = $signed(cfg_data);
        pidaw_pkg::CFG_DRIVE_MIN: drive_min_nxt = $signed(cfg_data);
        default: begin
          period_nxt = period_r;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    tsel_nxt       = tsel_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    err_nxt        = err_r;
    der_nxt        = der_r;
    error_sum_nxt  = error_sum_r;
    prev_error_nxt = prev_error_r;
    drive_nxt      = drive_r;
    limited_nxt    = limited_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        // Take a new item and update the integral and last error.
        if (in_acc) begin
          err_nxt        = err_in;
          der_nxt        = der_in;
          error_sum_nxt  = $signed(sat48(sum_add));
          prev_error_nxt = err_in;
          acc_nxt        = 64'sd0;
          tsel_nxt       = TERM_P;
          state_nxt      = S_LOAD;
        end
      end

      S_LOAD: begin
        // Set up magnitudes and sign of the current term.
        prod_nxt = 100'd0;
        cnt_nxt  = 6'd31;
        case (tsel_r)
          TERM_P: begin
            mcand_nxt  = {48'd0, mag32(err_r)};
            mplier_nxt = mag32(gain_p_r);
            neg_nxt    = err_r[31] ^ gain_p_r[31];
          end
          TERM_I: begin
            mcand_nxt  = {32'd0, mag48(error_sum_r)};
            mplier_nxt = mag32(gain_i_r);
            neg_nxt    = error_sum_r[47] ^ gain_i_r[31];
          end
          default: begin
            mcand_nxt  = {47'd0, mag33(der_r)};
            mplier_nxt = mag32(gain_d_r);
            neg_nxt    = der_r[32] ^ gain_d_r[31];
          end
        endcase
        state_nxt = S_MUL1;
      end

      S_MUL1: begin
        // Multiply by the gain magnitude, one bit per cycle, MSB first.
        prod_nxt   = alu_sum;
        mplier_nxt = {mplier_r[30:0], 1'b0};
        cnt_nxt    = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (tsel_r == TERM_P) begin
            state_nxt = S_ADD;
          end else begin
            mcand_nxt  = alu_sum[79:0];
            prod_nxt   = 100'd0;
            mplier_nxt = {mul2_op, 12'd0};
            cnt_nxt    = 6'd19;
            state_nxt  = S_MUL2;
          end
        end
      end

      S_MUL2: begin
        // Multiply by the period or by one million.
        prod_nxt   = alu_sum;
        mplier_nxt = {mplier_r[30:0], 1'b0};
        cnt_nxt    = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        // After the 2^16 scaling, a quotient of 2^61 or more saturates at once.
        if (alu_ge) begin
          prod_nxt  = {38'd0, pidaw_pkg::TERM_CAP};
          state_nxt = S_ADD;
        end else begin
          rem_nxt   = prod_r[96:77];
          prod_nxt  = {39'd0, prod_r[76:16]};
          cnt_nxt   = 6'd60;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_nxt  = alu_ge ? alu_sum[19:0] : {rem_r[18:0], prod_r[60]};
        prod_nxt = {39'd0, prod_r[59:0], alu_ge};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        // Accumulate the signed term and move to the next one.
        acc_nxt = acc_r + term_s;
        if (tsel_r == TERM_D) begin
          state_nxt = S_FIN;
        end else begin
          tsel_nxt  = tsel_r + 2'd1;
          state_nxt = S_LOAD;
        end
      end

      S_FIN: begin
        // Once the output slot is free, clamp, back out the error if needed and register the result.
        if (slot_free) begin
          drive_nxt     = drive_sat;
          limited_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (drive_max_r > drive_min_r) begin
            if (drive_sat > drive_max_r) begin
              drive_nxt   = drive_max_r;
              limited_nxt = 1'b1;
              if (err_r > 32'sd0) begin
                error_sum_nxt = $signed(sat48(sum_sub));
              end
            end else if (drive_sat < drive_min_r) begin
              drive_nxt   = drive_min_r;
              limited_nxt = 1'b1;
              if (err_r < 32'sd0) begin
                error_sum_nxt = $signed(sat48(sum_sub));
              end
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration, with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tsel_r       <= TERM_P;
      cnt_r        <= 6'd0;
      out_valid_r  <= 1'b0;
      error_sum_r  <= 48'sd0;
      prev_error_r <= 32'sd0;
      gain_p_r     <= 32'sd0;
      gain_i_r     <= 32'sd0;
      gain_d_r     <= 32'sd0;
      period_r     <= 20'd0;
      drive_max_r  <= 32'sd0;
      drive_min_r  <= 32'sd0;
    end else begin
      state_r      <= state_nxt;
      tsel_r       <= tsel_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      error_sum_r  <= error_sum_nxt;
      prev_error_r <= prev_error_nxt;
      gain_p_r     <= gain_p_nxt;
      gain_i_r     <= gain_i_nxt;
      gain_d_r     <= gain_d_nxt;
      period_r     <= period_nxt;
      drive_max_r  <= drive_max_nxt;
      drive_min_r  <= drive_min_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    rem_r     <= rem_nxt;
    neg_r     <= neg_nxt;
    err_r     <= err_nxt;
    der_r     <= der_nxt;
    drive_r   <= drive_nxt;
    limited_r <= limited_nxt;
  end

  // Conditions for the checks below.
  assign start_set   = (state_r == S_LOAD) && (tsel_r == TERM_P) && (acc_r == 64'sd0);
  assign sum_quiet   = !in_acc && (state_r != S_FIN);
  assign out_quiet   = (state_r != S_FIN) && !out_valid_r;
  assign div_add     = (state_r == S_ADD) && (tsel_r != TERM_P);
  assign term_cap_ok = (prod_r[61:0] <= pidaw_pkg::TERM_CAP);

  // An accepted item starts the proportional term with a cleared accumulator.
  `PIDAW_ASSERT_NEXT(a_start, clk, rst_n, in_acc, start_set, "item start not set up")

  // The integral changes only when an item is taken or at the final clamp step.
  `PIDAW_ASSERT_NEXT(a_sum_hold, clk, rst_n, sum_quiet, $stable(error_sum_r), "integral changed")

  // A result appears only out of the final step.
  `PIDAW_ASSERT_NEXT(a_out_src, clk, rst_n, out_quiet, !out_valid_r, "result without final step")

  // A divided term never exceeds the saturation cap.
  `PIDAW_ASSERT_NOW(a_term_cap, clk, rst_n, div_add, term_cap_ok, "term above cap")

endmodule

@@ dv/tb_pid_step_with_antiwindup_core.sv @@
`timescale 1ns / 1ps

// Fixed-point scale and saturation bounds used by the drive predictor.
localparam longint unsigned Q_SCALE = 64'd65536;
localparam longint S32_HI = 64'sh7FFF_FFFF;
localparam longint S32_LO = -S32_HI - 1;
localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
localparam longint SUM_LO = -SUM_HI - 1;

// Predicts the drive of each step and checks the block's results against it.
class drive_predictor;
  logic signed [31:0] kp, ki, kd, hi_limit, lo_limit;
  logic [pidaw_pkg::PERIOD_W-1:0] period;
  longint error_sum, last_error;
  pidaw_pkg::pidaw_out_t expected_drives[$];
  int items_noted, results_checked, clamp_count, mismatches;

  function new();
    kp = '0;
    ki = '0;
    kd = '0;
    hi_limit = '0;
    lo_limit = '0;
    period = '0;
    error_sum = 0;
    last_error = 0;
    items_noted = 0;
    results_checked = 0;
    clamp_count = 0;
    mismatches = 0;
  endfunction

  // Mirrors a register write; unknown indexes are dropped.
  function void set_reg(logic [pidaw_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
    case (index)
      pidaw_pkg::CFG_GAIN_P:    kp = value;
      pidaw_pkg::CFG_GAIN_I:    ki = value;
      pidaw_pkg::CFG_GAIN_D:    kd = value;
      pidaw_pkg::CFG_PERIOD:    period = value[pidaw_pkg::PERIOD_W-1:0];
      pidaw_pkg::CFG_DRIVE_MAX: hi_limit = value;
      pidaw_pkg::CFG_DRIVE_MIN: lo_limit = value;
      default: ;
    endcase
  endfunction

  function longint bound(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Signed a*b*mult/div, truncated toward zero on magnitudes and capped at 2^61.
  function longint scaled_term(longint a, longint b, longint unsigned mult,
                               longint unsigned div);
    logic [127:0] mag_a, mag_b, prod;
    longint r;
    mag_a = (a < 0) ? 128'(-a) : 128'(a);
    mag_b = (b < 0) ? 128'(-b) : 128'(b);
    prod = mag_a * mag_b * 128'(mult);
    prod = prod / 128'(div);
    if (prod > 128'(pidaw_pkg::TERM_CAP)) begin
      prod = 128'(pidaw_pkg::TERM_CAP);
    end
    r = longint'(prod[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Advances the controller state by one step and queues the expected result.
  function void note_input(pidaw_pkg::pidaw_in_t item);
    longint err, der, p_term, i_term, d_term, drv, hi, lo;
    longint unsigned per;
    pidaw_pkg::pidaw_out_t res;
    err = bound(longint'($signed(item.setpoint)) - longint'($signed(item.measured)),
                S32_LO, S32_HI);
    per = (period == 0) ? 64'(pidaw_pkg::DEFAULT_PERIOD_US) : 64'(period);
    error_sum = bound(error_sum + err, SUM_LO, SUM_HI);
    // A zero last error is seeded with this step's error, so the derivative is zero.
    if (last_error == 0) begin
      last_error = err;
    end
    der = err - last_error;
    p_term = scaled_term(err, kp, 64'd1, Q_SCALE);
    i_term = scaled_term(error_sum, ki, per, 64'(pidaw_pkg::US_PER_S) * Q_SCALE);
    d_term = scaled_term(der, kd, 64'(pidaw_pkg::US_PER_S), per * Q_SCALE);
    drv = bound(p_term + i_term + d_term, S32_LO, S32_HI);
    last_error = err;
    // Clamp only when the limits are ordered, and back the error out if it pushed outward.
    hi = hi_limit;
    lo = lo_limit;
    res.limited = 1'b0;
    if (hi > lo) begin
      if (drv > hi) begin
        drv = hi;
        res.limited = 1'b1;
        if (err > 0) begin
          error_sum = bound(error_sum - err, SUM_LO, SUM_HI);
        end
      end else if (drv < lo) begin
        drv = lo;
        res.limited = 1'b1;
        if (err < 0) begin
          error_sum = bound(error_sum - err, SUM_LO, SUM_HI);
        end
      end
    end
    res.drive = drv[31:0];
    expected_drives.push_back(res);
    items_noted++;
  endfunction

  // Compares one accepted result with the oldest expected one.
  function void check_result(pidaw_pkg::pidaw_out_t got);
    pidaw_pkg::pidaw_out_t want;
    results_checked++;
    if (expected_drives.size() == 0) begin
      if (mismatches < 10) begin
        $display("ERROR: result with nothing expected: drive=%0d limited=%0b",
                 $signed(got.drive), got.limited);
      end
      mismatches++;
      return;
    end
    want = expected_drives.pop_front();
    if (want.limited) begin
      clamp_count++;
    end
    if (got.drive !== want.drive || got.limited !== want.limited) begin
      if (mismatches < 10) begin
        $display("ERROR: result %0d: expected drive=%0d limited=%0b, got drive=%0d limited=%0b",
                 results_checked, $signed(want.drive), want.limited,
                 $signed(got.drive), got.limited);
      end
      mismatches++;
    end
  endfunction
endclass

module tb_pid_step_with_antiwindup_core;

  localparam int Q_ONE = 65536;
  localparam logic [31:0] S32_MAX_W = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN_W = 32'h8000_0000;
  localparam logic [pidaw_pkg::PERIOD_W-1:0] PERIOD_TOP = 20'hF_FFFF;
  localparam logic [pidaw_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [pidaw_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 20000;
  localparam int PRESSURE_AT = 300;
  localparam int PRESSURE_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pidaw_pkg::pidaw_in_t in_data;
  logic out_valid;
  logic out_stall;
  pidaw_pkg::pidaw_out_t out_data;
  logic cfg_we;
  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pidaw_pkg::CFG_DATA_W-1:0] cfg_data;

  bit tx_steady;
  bit rx_steady;
  int settings_used;

  drive_predictor pred = new();

  pid_step_with_antiwindup_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        pred.check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        pred.note_input(in_data);
      end
    end
  end

  // The run ends in failure when nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
    $display("pid_step_with_antiwindup_core test failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold while the sender keeps offering.
  initial begin : result_sink
    int hold;
    int r;
    bit pressure_done;
    hold = 0;
    pressure_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (!pressure_done && pred.results_checked >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        hold = PRESSURE_CYCLES - 1;
      end else if (rx_steady) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 400);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 70) begin
      return 0;
    end
    return (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 300);
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 5))
      0: return S32_MAX_W;
      1: return S32_MIN_W;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      default: return 32'(Q_ONE);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return S32_MAX_W;
      2: return S32_MIN_W;
      3: return $urandom();
      default: return 32'(int'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE);
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'd1000;
      3: return $urandom_range(1, 1000000);
      4: return 32'(PERIOD_TOP);
      // Bits above the register width must be dropped by the block.
      default: return $urandom();
    endcase
  endfunction

  // Mostly a measurement that tracks the setpoint, with some wild and corner items.
  function automatic pidaw_pkg::pidaw_in_t random_item();
    pidaw_pkg::pidaw_in_t item;
    int r;
    int base;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      base = int'($urandom_range(0, 2000 * Q_ONE)) - 1000 * Q_ONE;
      item.setpoint = base;
      item.measured = base - (int'($urandom_range(0, 100 * Q_ONE)) - 50 * Q_ONE);
    end else if (r < 70) begin
      item.setpoint = $urandom();
      item.measured = item.setpoint;
    end else if (r < 90) begin
      item.setpoint = $urandom();
      item.measured = $urandom();
    end else begin
      item.setpoint = corner_value();
      item.measured = corner_value();
    end
    return item;
  endfunction

  // Offers one item after a random gap and returns once it has been accepted.
  task automatic offer_item(logic [31:0] sp, logic [31:0] ms);
    int gap;
    pidaw_pkg::pidaw_in_t item;
    gap = pick_gap();
    item.setpoint = sp;
    item.measured = ms;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pred.expected_drives.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [pidaw_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    pred.set_reg(index, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                               logic [31:0] per, logic [31:0] hi, logic [31:0] lo);
    write_reg(pidaw_pkg::CFG_GAIN_P, p);
    write_reg(pidaw_pkg::CFG_GAIN_I, i);
    write_reg(pidaw_pkg::CFG_GAIN_D, d);
    write_reg(pidaw_pkg::CFG_PERIOD, per);
    write_reg(pidaw_pkg::CFG_DRIVE_MAX, hi);
    write_reg(pidaw_pkg::CFG_DRIVE_MIN, lo);
    settings_used++;
  endtask

  // Random gains, period and limits; limits may be narrow, wide, equal or reversed.
  task automatic randomize_setting();
    logic [31:0] hi;
    logic [31:0] lo;
    case ($urandom_range(0, 4))
      0: begin
        hi = $urandom_range(0, 200 * Q_ONE);
        lo = -int'($urandom_range(0, 200 * Q_ONE));
      end
      1: begin
        hi = S32_MAX_W;
        lo = S32_MIN_W;
      end
      2: begin
        hi = $urandom();
        lo = hi;
      end
      3: begin
        hi = -int'($urandom_range(1, 50 * Q_ONE));
        lo = $urandom_range(0, 50 * Q_ONE);
      end
      default: begin
        hi = $urandom();
        lo = $urandom();
      end
    endcase
    apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_period(), hi, lo);
    write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
  endtask

  initial begin : stimulus
    int phase_idx;
    int n;
    pidaw_pkg::pidaw_in_t item;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settings_used = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: all gains zero and the limits equal, so the drive stays zero.
    offer_item(32'(3 * Q_ONE), 32'h0);
    offer_item(32'h0, 32'h0);
    offer_item(S32_MIN_W, S32_MAX_W);
    drain();

    // Directed steps with plain gains, the default period and limits of +-100.
    apply_setting(32'(Q_ONE), 32'(Q_ONE / 2), 32'(Q_ONE / 4), 32'h0,
                  32'(100 * Q_ONE), 32'(-100 * Q_ONE));
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h1234_5678);
    offer_item(32'h0, 32'h0);
    offer_item(32'(5 * Q_ONE), 32'h0);
    offer_item(32'(8 * Q_ONE), 32'(Q_ONE));
    offer_item(32'(200 * Q_ONE), 32'h0);
    offer_item(32'(-300 * Q_ONE), 32'h0);
    offer_item(S32_MAX_W, S32_MIN_W);
    offer_item(S32_MIN_W, S32_MAX_W);
    offer_item(S32_MIN_W, S32_MIN_W);
    offer_item(S32_MAX_W, S32_MAX_W);
    offer_item(32'hFFFF_FFFF, 32'h0);
    offer_item(32'h1, 32'h0);
    offer_item(32'h0, S32_MIN_W);
    offer_item(32'h0, S32_MAX_W);
    offer_item(32'(3 * Q_ONE), 32'(3 * Q_ONE));
    offer_item(32'(2 * Q_ONE), 32'h0);
    drain();

    // Negative P gain against tight limits: clamps where the error pushes the other way.
    apply_setting(32'(-Q_ONE), 32'(Q_ONE), 32'(Q_ONE), 32'(PERIOD_TOP),
                  32'(Q_ONE), 32'(-Q_ONE));
    offer_item(32'(10 * Q_ONE), 32'h0);
    offer_item(32'(-10 * Q_ONE), 32'h0);
    offer_item(32'h0, 32'(20 * Q_ONE));
    offer_item(32'(Q_ONE / 2), 32'h0);
    drain();

    // Random phases: two extreme settings first, then random ones.
    for (phase_idx = 0; phase_idx < 9; phase_idx++) begin
      case (phase_idx)
        0: apply_setting(S32_MAX_W, S32_MIN_W, S32_MIN_W, 32'h1, S32_MAX_W, S32_MIN_W);
        1: apply_setting(S32_MIN_W, S32_MAX_W, S32_MAX_W, 32'(PERIOD_TOP),
                         S32_MIN_W, S32_MAX_W);
        default: randomize_setting();
      endcase
      tx_steady = (phase_idx % 4 == 3);
      rx_steady = (phase_idx % 4 == 2);
      for (n = 0; n < 100; n++) begin
        item = random_item();
        offer_item(item.setpoint, item.measured);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    $display("Ran %0d steps under %0d register settings; %0d results checked, %0d clamped.",
             pred.items_noted, settings_used, pred.results_checked, pred.clamp_count);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             pred.mismatches, pred.expected_drives.size());
    if (pred.mismatches == 0 && pred.expected_drives.size() == 0) begin
      $display("pid_step_with_antiwindup_core test passed");
    end else begin
      $display("pid_step_with_antiwindup_core test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/pidaw_pkg.sv
src/pid_step_with_antiwindup_core.sv
dv/tb_pid_step_with_antiwindup_core.sv
